>>> rtl/core/biquad_cascade_filter_macros.svh
// assertion macros shared by the filter modules
`ifndef BIQUAD_CASCADE_FILTER_MACROS_SVH
`define BIQUAD_CASCADE_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define BQC_ASSERT_IMP(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("bqc assertion failed");

// next-cycle implication, disabled during reset
`define BQC_ASSERT_NXT(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("bqc assertion failed");

`else

`define BQC_ASSERT_IMP(name, clk, rst_n, cond, expr)
`define BQC_ASSERT_NXT(name, clk, rst_n, cond, expr)

`endif

`endif

>>> rtl/core/bqc_pkg.sv
`timescale 1ns / 1ps

package bqc_pkg;

    // configuration defaults and fixed widths
    localparam int SECTIONS_DEF   = 8;
    localparam int COEFS_PER_SIDE = 3;
    localparam int COEFS_PER_SEC  = 2 * COEFS_PER_SIDE - 1;
    localparam int SMP_W          = 24;
    localparam int COEF_W         = 32;
    localparam int PROD_W         = SMP_W + COEF_W;
    localparam int ST_W           = 48;
    localparam int SUM_W          = ST_W + 2;
    localparam int SEC_W          = 3;
    localparam int CIDX_W         = 3;

    // request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    // coefficient codes within a section
    localparam logic [CIDX_W-1:0] COEF_B0 = 3'd0;
    localparam logic [CIDX_W-1:0] COEF_B1 = 3'd1;
    localparam logic [CIDX_W-1:0] COEF_B2 = 3'd2;
    localparam logic [CIDX_W-1:0] COEF_A1 = 3'd3;
    localparam logic [CIDX_W-1:0] COEF_A2 = 3'd4;

    // saturation limits
    localparam logic signed [SMP_W-1:0] S24_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic signed [SMP_W-1:0] S24_MIN = {1'b1, {(SMP_W-1){1'b0}}};
    localparam logic signed [ST_W-1:0]  S48_MAX = {1'b0, {(ST_W-1){1'b1}}};
    localparam logic signed [ST_W-1:0]  S48_MIN = {1'b1, {(ST_W-1){1'b0}}};

    // sample handed from one section to the next
    typedef struct packed {
        logic                    valid;
        logic signed [SMP_W-1:0] sample;
        logic                    clip;
    } t_link;

    // coefficient write broadcast to all sections
    typedef struct packed {
        logic                     en;
        logic [SEC_W-1:0]         section;
        logic [CIDX_W-1:0]        coef;
        logic signed [COEF_W-1:0] value;
    } t_coef_wr;

    // q.30 product to q.22, round half up
    function automatic logic signed [ST_W-1:0] rnd_prod(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + 56'sd128;
        return s[PROD_W-1:PROD_W-ST_W];
    endfunction

    // clamp a grown state sum to 48 bits
    function automatic logic signed [ST_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
        logic signed [ST_W-1:0] r;
        if (v[SUM_W-1:ST_W-1] == {3{v[ST_W-1]}}) begin
            r = v[ST_W-1:0];
        end else if (v[SUM_W-1]) begin
            r = S48_MIN;
        end else begin
            r = S48_MAX;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/bqc_cell.sv
`timescale 1ns / 1ps
`include "biquad_cascade_filter_macros.svh"

module bqc_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bqc_pkg::t_link      i_link,
    input  bqc_pkg::t_coef_wr   i_coef_wr,
    input  logic                i_clear,
    output bqc_pkg::t_link      o_link,
    output logic                o_done
);

    // section sequencer steps
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_B0   = 3'd1;
    localparam logic [2:0] ST_Y    = 3'd2;
    localparam logic [2:0] ST_A1   = 3'd3;
    localparam logic [2:0] ST_D1   = 3'd4;
    localparam logic [2:0] ST_A2   = 3'd5;
    localparam logic [2:0] ST_D2   = 3'd6;

    logic [2:0]                              r_step;
    logic                                    r_ov;
    logic                                    r_done;
    logic                                    r_clip;
    logic signed [bqc_pkg::SMP_W-1:0]        r_x;
    logic signed [bqc_pkg::SMP_W-1:0]        r_y;
    logic signed [bqc_pkg::PROD_W-1:0]       r_prod;
    logic signed [bqc_pkg::ST_W-1:0]         r_t;
    logic signed [bqc_pkg::ST_W-1:0]         r_d1;
    logic signed [bqc_pkg::ST_W-1:0]         r_d2;
    logic signed [bqc_pkg::COEF_W-1:0]       r_coef [bqc_pkg::COEFS_PER_SEC];

    logic signed [bqc_pkg::COEF_W-1:0]       mul_c;
    logic signed [bqc_pkg::SMP_W-1:0]        mul_x;
    logic signed [bqc_pkg::PROD_W-1:0]       prod_w;
    logic signed [bqc_pkg::ST_W-1:0]         rnd_w;
    logic signed [bqc_pkg::SUM_W-1:0]        acc_w;
    logic signed [bqc_pkg::SUM_W-23:0]       yq_w;
    logic                                    y_clip;
    logic signed [bqc_pkg::SMP_W-1:0]        y_sat;
    logic signed [bqc_pkg::SUM_W-1:0]        d1_sum;
    logic signed [bqc_pkg::SUM_W-1:0]        d2_sum;
    logic                                    wr_hit;

    // coefficient store, one entry per coefficient of this section
    assign wr_hit = i_coef_wr.en && (int'(i_coef_wr.section) == CELL_IDX)
                    && (int'(i_coef_wr.coef) < bqc_pkg::COEFS_PER_SEC);

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_coef[i_coef_wr.coef] <= i_coef_wr.value;
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (r_step)
            ST_B0: begin
                mul_c = r_coef[bqc_pkg::COEF_B0];
                mul_x = r_x;
            end
            ST_Y: begin
                mul_c = r_coef[bqc_pkg::COEF_B1];
                mul_x = r_x;
            end
            ST_A1: begin
                mul_c = r_coef[bqc_pkg::COEF_A1];
                mul_x = r_y;
            end
            ST_D1: begin
                mul_c = r_coef[bqc_pkg::COEF_B2];
                mul_x = r_x;
            end
            ST_A2: begin
                mul_c = r_coef[bqc_pkg::COEF_A2];
                mul_x = r_y;
            end
            default: begin
                mul_c = r_coef[bqc_pkg::COEF_B0];
                mul_x = r_x;
            end
        endcase
    end

    assign prod_w = mul_c * mul_x;
    assign rnd_w  = bqc_pkg::rnd_prod(r_prod);

    // section output: b0 term plus first delay, back to 24 bits
    assign acc_w  = bqc_pkg::SUM_W'(rnd_w) + bqc_pkg::SUM_W'(r_d1) + 50'sd2097152;
    assign yq_w   = acc_w[bqc_pkg::SUM_W-1:22];
    assign y_clip = (yq_w[bqc_pkg::SUM_W-23:bqc_pkg::SMP_W-1] != {5{yq_w[bqc_pkg::SMP_W-1]}});

    always_comb begin
        if (!y_clip) begin
            y_sat = yq_w[bqc_pkg::SMP_W-1:0];
        end else if (yq_w[bqc_pkg::SUM_W-23]) begin
            y_sat = bqc_pkg::S24_MIN;
        end else begin
            y_sat = bqc_pkg::S24_MAX;
        end
    end

    // delay updates
    assign d1_sum = bqc_pkg::SUM_W'(r_t) - bqc_pkg::SUM_W'(rnd_w) + bqc_pkg::SUM_W'(r_d2);
    assign d2_sum = bqc_pkg::SUM_W'(r_t) - bqc_pkg::SUM_W'(rnd_w);

    // sequencer and handoff pulses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
            r_ov   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_ov   <= (r_step == ST_Y);
            r_done <= (r_step == ST_D2);
            unique case (r_step)
                ST_IDLE: begin
                    if (i_link.valid) begin
                        r_step <= ST_B0;
                    end
                end
                ST_B0:   r_step <= ST_Y;
                ST_Y:    r_step <= ST_A1;
                ST_A1:   r_step <= ST_D1;
                ST_D1:   r_step <= ST_A2;
                ST_A2:   r_step <= ST_D2;
                ST_D2:   r_step <= ST_IDLE;
                default: r_step <= ST_IDLE;
            endcase
        end
    end

    // delay states, cleared by reset and at end of block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else begin
            if (r_step == ST_D1) begin
                r_d1 <= bqc_pkg::sat48(d1_sum);
            end
            if (r_step == ST_D2) begin
                r_d2 <= bqc_pkg::sat48(d2_sum);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= prod_w;
        if (r_step == ST_IDLE && i_link.valid) begin
            r_x    <= i_link.sample;
            r_clip <= i_link.clip;
        end
        if (r_step == ST_Y) begin
            r_y    <= y_sat;
            r_clip <= r_clip | y_clip;
        end
        if (r_step == ST_A1 || r_step == ST_A2) begin
            r_t <= rnd_w;
        end
    end

    assign o_link.valid  = r_ov;
    assign o_link.sample = r_y;
    assign o_link.clip   = r_clip;
    assign o_done        = r_done;

    // sequencer runs straight through once started
    `BQC_ASSERT_NXT(a_cell_seq, i_clk, i_rst_n, (r_step != ST_IDLE && r_step != ST_D2), (r_step == $past(r_step) + 3'd1))
    // a new sample only reaches an idle section
    `BQC_ASSERT_IMP(a_cell_start_idle, i_clk, i_rst_n, i_link.valid, (r_step == ST_IDLE))
    // block clear never lands on a section still updating
    `BQC_ASSERT_IMP(a_cell_clear_idle, i_clk, i_rst_n, i_clear, (r_step == ST_IDLE && !i_link.valid))

endmodule

>>> rtl/core/biquad_cascade_filter.sv
`timescale 1ns / 1ps
`include "biquad_cascade_filter_macros.svh"

// channel   direction  handshake                   payload
// request   in         i_in_valid / o_in_ready     req_type, section_index, coef_index,
//                                                  coef_value, sample_in, last_in_block
// result    out        o_out_valid / i_out_ready   sample_out, clipped
//
// a coefficient write lands in its section's store as it is accepted and leaves the block ready;
// a sample holds off the next item from acceptance until its result moves out of the chain, a span
// set by the section chain where each section hands its output on after its b0 and y steps
// and the last one still runs its a1, d1, a2 and d2 delay-update steps on its single multiplier.
// reset clears the delay states and all control; coefficients hold garbage until written.
// a stalled result waits in the output register; the next sample is taken once it moves there.

module biquad_cascade_filter #(
    parameter int SECTIONS = bqc_pkg::SECTIONS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_req_type,
    input  logic [bqc_pkg::SEC_W-1:0]           i_section_index,
    input  logic [bqc_pkg::CIDX_W-1:0]          i_coef_index,
    input  logic signed [bqc_pkg::COEF_W-1:0]   i_coef_value,
    input  logic signed [bqc_pkg::SMP_W-1:0]    i_sample_in,
    input  logic                                i_last_in_block,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [bqc_pkg::SMP_W-1:0]    o_sample_out,
    output logic                                o_clipped
);

    logic                               r_busy;
    logic                               r_last;
    logic                               r_pend;
    logic                               r_clr;
    logic                               r_feed_valid;
    logic signed [bqc_pkg::SMP_W-1:0]   r_feed_sample;
    logic                               r_out_valid;
    logic signed [bqc_pkg::SMP_W-1:0]   r_out_sample;
    logic                               r_out_clip;

    logic                               in_acc;
    logic                               sample_acc;
    logic                               chain_done;
    logic                               move_out;
    bqc_pkg::t_coef_wr                  coef_wr;
    bqc_pkg::t_link                     links [SECTIONS+1];
    logic [SECTIONS-1:0]                done_w;

    assign o_in_ready = !r_busy;
    assign in_acc     = i_in_valid && o_in_ready;
    assign sample_acc = in_acc && (i_req_type == bqc_pkg::REQ_SAMPLE);

    // coefficient writes go straight to the sections
    assign coef_wr.en      = in_acc && (i_req_type == bqc_pkg::REQ_COEF);
    assign coef_wr.section = i_section_index;
    assign coef_wr.coef    = i_coef_index;
    assign coef_wr.value   = i_coef_value;

    // head of the chain
    assign links[0].valid  = r_feed_valid;
    assign links[0].sample = r_feed_sample;
    assign links[0].clip   = 1'b0;

    // section chain
    for (genvar g = 0; g < SECTIONS; g++) begin : g_cell
        bqc_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_link    (links[g]),
            .i_coef_wr (coef_wr),
            .i_clear   (r_clr),
            .o_link    (links[g+1]),
            .o_done    (done_w[g])
        );
    end

    assign chain_done = done_w[SECTIONS-1];
    assign move_out   = r_pend && (!r_out_valid || i_out_ready);

    // item control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_pend       <= 1'b0;
            r_clr        <= 1'b0;
            r_feed_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_feed_valid <= sample_acc;
            r_clr        <= chain_done && r_last;
            if (sample_acc) begin
                r_busy <= 1'b1;
            end else if (move_out) begin
                r_busy <= 1'b0;
            end
            if (chain_done) begin
                r_pend <= 1'b1;
            end else if (move_out) begin
                r_pend <= 1'b0;
            end
            if (move_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (sample_acc) begin
            r_feed_sample <= i_sample_in;
            r_last        <= i_last_in_block;
        end
        if (move_out) begin
            r_out_sample <= links[SECTIONS].sample;
            r_out_clip   <= links[SECTIONS].clip;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_clipped    = r_out_clip;

    // sections only finish while a sample is in flight
    `BQC_ASSERT_IMP(a_done_busy, i_clk, i_rst_n, (|done_w), r_busy)
    // sections finish at distinct times
    `BQC_ASSERT_IMP(a_done_single, i_clk, i_rst_n, 1'b1, $onehot0(done_w))
    // an accepted sample enters the chain and holds off new items
    `BQC_ASSERT_NXT(a_sample_busy, i_clk, i_rst_n, sample_acc, (r_busy && r_feed_valid))
    // block clear happens while its result is still pending
    `BQC_ASSERT_IMP(a_clr_pending, i_clk, i_rst_n, r_clr, (r_pend && r_busy))

endmodule

>>> test/biquad_filter_checker.sv
`timescale 1ns / 1ps

module biquad_filter_checker #(
    parameter int SECTIONS = bqc_pkg::SECTIONS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_req_type,
    input  logic [bqc_pkg::SEC_W-1:0]           i_section_index,
    input  logic [bqc_pkg::CIDX_W-1:0]          i_coef_index,
    input  logic signed [bqc_pkg::COEF_W-1:0]   i_coef_value,
    input  logic signed [bqc_pkg::SMP_W-1:0]    i_sample_in,
    input  logic                                i_last_in_block,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [bqc_pkg::SMP_W-1:0]    i_sample_out,
    input  logic                                i_clipped,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import bqc_pkg::*;

    // one filtered sample as the block should return it
    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    clip;
    } t_filtered;

    // own copy of the coefficient table and the section delay pairs
    logic signed [COEF_W-1:0] coef_bank [SECTIONS][COEFS_PER_SEC];
    longint                   delay_line [SECTIONS][COEFS_PER_SIDE-1];
    t_filtered                filtered_q [$];
    int                       fails = 0;

    // exact q.30 product, rounded half up to q.22
    function automatic longint mul_q22(input logic signed [COEF_W-1:0] c, input longint x);
        longint p;
        p = longint'(c) * x;
        return (p + 64'sd128) >>> 8;
    endfunction

    // clamp a state sum to the 48-bit range
    function automatic longint clamp_state(input longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< 47) - 64'sd1;
        lo = -(64'sd1 <<< 47);
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // push one sample through every section and update the delays
    function automatic t_filtered run_cascade(input logic signed [SMP_W-1:0] smp,
                                              input logic last);
        longint    x;
        longint    acc;
        longint    y;
        logic      clip;
        t_filtered res;
        x = longint'(smp);
        clip = 1'b0;
        for (int s = 0; s < SECTIONS; s++) begin
            acc = mul_q22(coef_bank[s][COEF_B0], x) + delay_line[s][0];
            y = (acc + (64'sd1 <<< 21)) >>> 22;
            if (y > longint'(S24_MAX)) begin
                y = longint'(S24_MAX);
                clip = 1'b1;
            end else if (y < longint'(S24_MIN)) begin
                y = longint'(S24_MIN);
                clip = 1'b1;
            end
            delay_line[s][0] = clamp_state(mul_q22(coef_bank[s][COEF_B1], x)
                                           - mul_q22(coef_bank[s][COEF_A1], y)
                                           + delay_line[s][1]);
            delay_line[s][1] = clamp_state(mul_q22(coef_bank[s][COEF_B2], x)
                                           - mul_q22(coef_bank[s][COEF_A2], y));
            x = y;
        end
        // end of a block starts the next one from rest
        if (last) begin
            for (int s = 0; s < SECTIONS; s++) begin
                delay_line[s][0] = '0;
                delay_line[s][1] = '0;
            end
        end
        res.sample = x[SMP_W-1:0];
        res.clip = clip;
        return res;
    endfunction

    // watch both channels, compare results, then record new items
    always @(posedge i_clk) begin : watch
        t_filtered want;
        if (!i_rst_n) begin
            for (int s = 0; s < SECTIONS; s++) begin
                delay_line[s][0] = '0;
                delay_line[s][1] = '0;
            end
            filtered_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (filtered_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, got sample %0d clip %0b",
                             $time, i_sample_out, i_clipped);
                end else begin
                    want = filtered_q.pop_front();
                    if (i_sample_out !== want.sample) begin
                        fails++;
                        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                                 $time, want.sample, i_sample_out);
                    end
                    if (i_clipped !== want.clip) begin
                        fails++;
                        $display("%0t: clipped mismatch, expected %0b, got %0b",
                                 $time, want.clip, i_clipped);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_req_type == REQ_COEF) begin
                    if (int'(i_section_index) < SECTIONS
                        && int'(i_coef_index) < COEFS_PER_SEC) begin
                        coef_bank[i_section_index][i_coef_index] = i_coef_value;
                    end
                end else begin
                    filtered_q.push_back(run_cascade(i_sample_in, i_last_in_block));
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= filtered_q.size();
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bqc_pkg::*;

    localparam int ITEM_TARGET = 1350;
    localparam int CALM_AFTER  = 1200;
    localparam int HOLD_AT     = 300;
    localparam int DRAIN_AT    = 700;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL        = 40;
    localparam int CYCLE_LIMIT = 1000000;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     req_type;
    logic [SEC_W-1:0]         section_index;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [SMP_W-1:0]  sample_in;
    logic                     last_in_block;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [SMP_W-1:0]  sample_out;
    logic                     clipped;
    int                       fail_count;
    int                       pending;
    int                       cycles = 0;
    bit                       calm = 1'b0;
    bit                       hold_req = 1'b0;
    bit                       hold_done = 1'b0;

    biquad_cascade_filter dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_req_type      (req_type),
        .i_section_index (section_index),
        .i_coef_index    (coef_index),
        .i_coef_value    (coef_value),
        .i_sample_in     (sample_in),
        .i_last_in_block (last_in_block),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_sample_out    (sample_out),
        .o_clipped       (clipped)
    );

    biquad_filter_checker filter_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_req_type      (req_type),
        .i_section_index (section_index),
        .i_coef_index    (coef_index),
        .i_coef_value    (coef_value),
        .i_sample_in     (sample_in),
        .i_last_in_block (last_in_block),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_sample_out    (sample_out),
        .i_clipped       (clipped),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off, steady at the end
    initial begin : result_side
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req && !hold_done) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, calm ? 1 : 19)) @(posedge clk);
            end
        end
    end

    // offer one item and hold it until taken
    task automatic offer(input logic rt, input logic [SEC_W-1:0] sec,
                         input logic [CIDX_W-1:0] ci, input logic signed [COEF_W-1:0] cv,
                         input logic signed [SMP_W-1:0] sv, input logic lst);
        in_valid <= 1'b1;
        req_type <= rt;
        section_index <= sec;
        coef_index <= ci;
        coef_value <= cv;
        sample_in <= sv;
        last_in_block <= lst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // coefficient write with junk in the unused fields
    task automatic write_coef(input logic [SEC_W-1:0] sec, input logic [CIDX_W-1:0] ci,
                              input logic signed [COEF_W-1:0] cv);
        bit [31:0] r;
        r = $urandom();
        offer(REQ_COEF, sec, ci, cv, r[SMP_W-1:0], r[31]);
    endtask

    // sample with junk in the unused fields
    task automatic feed(input logic signed [SMP_W-1:0] sv, input logic lst);
        bit [31:0] r;
        r = $urandom();
        offer(REQ_SAMPLE, r[2:0], r[5:3], $urandom(), sv, lst);
    endtask

    task automatic gap(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // stop sending until every filtered sample is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // coefficient of a stable section
    function automatic logic signed [COEF_W-1:0] gentle_coef(input logic [CIDX_W-1:0] ci);
        if (ci == COEF_A2) begin
            return int'($urandom_range(0, 1 << 29)) - (1 << 28);
        end
        return int'($urandom_range(0, 1 << 30)) - (1 << 29);
    endfunction

    function automatic logic signed [COEF_W-1:0] wild_coef();
        bit [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return 32'sh4000_0000;
            default: return r;
        endcase
    endfunction

    function automatic logic signed [SMP_W-1:0] pick_sample();
        bit [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return r[SMP_W-1:0];
            6, 7: return SMP_W'(int'($urandom_range(0, 2000)) - 1000);
            8: return r[0] ? S24_MAX : S24_MIN;
            default: return r[0] ? 24'sd0 : -24'sd1;
        endcase
    endfunction

    task automatic load_section(input logic [SEC_W-1:0] sec);
        write_coef(sec, COEF_B0, gentle_coef(COEF_B0));
        write_coef(sec, COEF_B1, gentle_coef(COEF_B1));
        write_coef(sec, COEF_B2, gentle_coef(COEF_B2));
        write_coef(sec, COEF_A1, gentle_coef(COEF_A1));
        write_coef(sec, COEF_A2, gentle_coef(COEF_A2));
    endtask

    // request side: setup, directed items, random items, verdict
    initial begin : request_side
        int                     n_items;
        int                     pick;
        bit                     drained_mid;
        logic [CIDX_W-1:0]      ci;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_SAMPLE;
        section_index = '0;
        coef_index = '0;
        coef_value = '0;
        sample_in = '0;
        last_in_block = 1'b0;
        n_items = 0;
        drained_mid = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // fill the whole table: a smoothing first section, pass-through after it
        for (int s = 0; s < SECTIONS_DEF; s++) begin
            write_coef(SEC_W'(s), COEF_B0, (s == 0) ? 32'sh1000_0000 : 32'sh4000_0000);
            write_coef(SEC_W'(s), COEF_B1, (s == 0) ? 32'sh2000_0000 : 32'sh0);
            write_coef(SEC_W'(s), COEF_B2, (s == 0) ? 32'sh1000_0000 : 32'sh0);
            write_coef(SEC_W'(s), COEF_A1, (s == 0) ? -32'sh2000_0000 : 32'sh0);
            write_coef(SEC_W'(s), COEF_A2, (s == 0) ? 32'sh0800_0000 : 32'sh0);
        end

        // full-scale and near-zero samples, block end
        feed(S24_MAX, 1'b0);
        feed(S24_MIN, 1'b0);
        feed(24'sd0, 1'b0);
        feed(-24'sd1, 1'b1);
        feed(24'sd1, 1'b0);
        // writes to codes past a2 change nothing
        write_coef(3'd7, 3'd5, 32'sh7FFF_FFFF);
        write_coef(3'd0, 3'd7, 32'sh8000_0000);
        feed(24'sd12345, 1'b1);
        // largest gain in the last section drives the output into clipping
        write_coef(3'd7, COEF_B0, 32'sh7FFF_FFFF);
        feed(S24_MAX, 1'b0);
        feed(S24_MIN, 1'b1);
        write_coef(3'd7, COEF_B0, 32'sh8000_0000);
        feed(S24_MAX, 1'b0);
        feed(S24_MIN, 1'b1);
        // strong feedback pushes the delay states into their limits
        write_coef(3'd7, COEF_A1, 32'sh8000_0000);
        write_coef(3'd7, COEF_A2, 32'sh8000_0000);
        feed(S24_MAX, 1'b0);
        feed(S24_MAX, 1'b0);
        feed(S24_MIN, 1'b0);
        feed(S24_MAX, 1'b1);
        write_coef(3'd7, COEF_B0, 32'sh4000_0000);
        write_coef(3'd7, COEF_A1, 32'sh0);
        write_coef(3'd7, COEF_A2, 32'sh0);
        feed(-24'sd4096, 1'b1);
        drain();

        // random traffic: mostly samples through stable sections
        while (n_items < ITEM_TARGET) begin
            if (n_items >= CALM_AFTER) begin
                calm = 1'b1;
            end
            if (n_items >= HOLD_AT) begin
                hold_req = 1'b1;
            end
            if (n_items >= DRAIN_AT && !drained_mid) begin
                drain();
                drained_mid = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                load_section(SEC_W'($urandom_range(0, SECTIONS_DEF - 1)));
                n_items += COEFS_PER_SEC;
            end else if (pick < 16) begin
                ci = CIDX_W'($urandom_range(0, 7));
                write_coef(SEC_W'($urandom_range(0, 7)), ci, wild_coef());
                if (int'(ci) < COEFS_PER_SEC) begin
                    n_items++;
                end
            end else begin
                feed(pick_sample(), $urandom_range(0, 19) == 0);
                n_items++;
            end
            if (!calm && $urandom_range(0, 3) == 0) begin
                gap($urandom_range(1, 19));
            end
        end

        drain();
        repeat (TAIL) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
